@@ rtl/assert_macros.svh @@
// Assertion macros shared by the converter RTL.
// Expands to concurrent assertions in simulation and to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

@@ rtl/b2da_pkg.sv @@
// Shared types and constants of the binary to decimal ASCII converter.
// Used by b2da_cell and binary_to_decimal_ascii; depends on nothing.
package b2da_pkg;

   localparam int VALUE_W    = 32;
   localparam int DIGIT_W    = 4;
   localparam int NUM_DIGITS = 10;
   localparam int CHAR_W     = 6;
   localparam int POS_W      = 4;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 16;

   localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

   typedef logic [DIGIT_W-1:0] digit_type;

   // Cell operations
   localparam logic [1:0] CELL_HOLD  = 2'd0;
   localparam logic [1:0] CELL_CLEAR = 2'd1;
   localparam logic [1:0] CELL_BIT   = 2'd2;
   localparam logic [1:0] CELL_DIGIT = 2'd3;

   typedef struct packed {
      logic [1:0] op;
   } cell_ctrl_type;

endpackage

@@ rtl/b2da_cell.sv @@
// One BCD digit cell of the converter chain: add-3 adjust and shift.
// Depends on b2da_pkg.
module b2da_cell (
   input  logic                  clock,
   input  b2da_pkg::cell_ctrl_type ctrl,
   input  logic                  carry_in,
   input  b2da_pkg::digit_type   digit_in,
   output logic                  carry_out,
   output b2da_pkg::digit_type   digit
);
   import b2da_pkg::*;

   digit_type digit_ff;
   digit_type digit_in_w;
   digit_type adj_w;

   // Adjust a digit of five or more before it doubles
   always_comb begin
      if (digit_ff >= 4'd5) begin
         adj_w = digit_ff + 4'd3;
      end else begin
         adj_w = digit_ff;
      end
   end

   assign carry_out = adj_w[DIGIT_W-1];

   // Select next digit: hold, clear, shift in one bit, or take neighbor digit
   always_comb begin
      case (ctrl.op)
         CELL_HOLD:  digit_in_w = digit_ff;
         CELL_CLEAR: digit_in_w = '0;
         CELL_BIT:   digit_in_w = {adj_w[DIGIT_W-2:0], carry_in};
         CELL_DIGIT: digit_in_w = digit_in;
         default:    digit_in_w = digit_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in_w;
   end

   assign digit = digit_ff;

endmodule

@@ rtl/binary_to_decimal_ascii.sv @@
// Top level of the binary to decimal ASCII converter: control and output register.
// Depends on b2da_pkg, b2da_cell and assert_macros.svh.
//
//  channel | dir | tdata fields (low bit up)                          | tuser | tlast
//  req_    | in  | value[31:0]                                        | -     | -
//  rsp_    | out | digit_char[5:0] position[9:6] digit_count[13:10]   | -     | last
//
// A value passes through its acceptance, a shift-add-3 pass of each of its 32 bits through the row of ten
// digit cells, a step that drops leading zeros and the emission of its n digits; emission
// stalls while a digit waits on rsp_tready low.
// One value is in flight at a time; req_tready is high only while idle.
// The next value is taken while the final digit still waits in the output register.
// Reset is synchronous and clears control state only.
`include "assert_macros.svh"
module binary_to_decimal_ascii (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [b2da_pkg::REQ_DATA_W-1:0]    req_tdata,   // value[31:0]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [b2da_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // digit_char[5:0],
                                                           // position[9:6],
                                                           // digit_count[13:10]
   output logic                               rsp_tlast
);
   import b2da_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CONV  = 2'd1;
   localparam logic [1:0] ST_ALIGN = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   localparam logic [4:0]       LAST_BIT   = 5'(VALUE_W - 1);
   localparam logic [POS_W-1:0] MAX_COUNT  = POS_W'(NUM_DIGITS);

   logic [1:0]          state_ff, state_in;
   logic [VALUE_W-1:0]  bin_ff, bin_in;
   logic [4:0]          bit_cnt_ff, bit_cnt_in;
   logic [POS_W-1:0]    count_ff, count_in;
   logic [POS_W-1:0]    pos_ff, pos_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]   rsp_char_ff, rsp_char_in;
   logic [POS_W-1:0]    rsp_pos_ff, rsp_pos_in;
   logic [POS_W-1:0]    rsp_count_ff, rsp_count_in;
   logic                rsp_last_ff, rsp_last_in;

   cell_ctrl_type       cell_ctrl;
   digit_type           digit_w [NUM_DIGITS];
   logic [NUM_DIGITS:0] carry_w;

   logic                req_beat;
   logic                slot_free;
   digit_type           top_digit;

   assign req_beat   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign top_digit  = digit_w[NUM_DIGITS-1];
   assign req_tready = (state_ff == ST_IDLE);
   assign carry_w[0] = bin_ff[VALUE_W-1];

   // Row of digit cells, least significant at index zero
   for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
      digit_type nbr_digit;
      if (i == 0) begin : g_first
         assign nbr_digit = '0;
      end else begin : g_rest
         assign nbr_digit = digit_w[i-1];
      end
      b2da_cell u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl),
         .carry_in  (carry_w[i]),
         .digit_in  (nbr_digit),
         .carry_out (carry_w[i+1]),
         .digit     (digit_w[i])
      );
   end

   // Sequence conversion, zero stripping and digit emission
   always_comb begin
      state_in     = state_ff;
      bin_in       = bin_ff;
      bit_cnt_in   = bit_cnt_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      cell_ctrl.op = CELL_HOLD;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_char_in  = rsp_char_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               bin_in       = req_tdata;
               bit_cnt_in   = '0;
               cell_ctrl.op = CELL_CLEAR;
               state_in     = ST_CONV;
            end
         end
         ST_CONV: begin
            // Shift one bit from the top of the value into the cell row
            cell_ctrl.op = CELL_BIT;
            bin_in       = {bin_ff[VALUE_W-2:0], 1'b0};
            bit_cnt_in   = bit_cnt_ff + 5'd1;
            if (bit_cnt_ff == LAST_BIT) begin
               count_in = MAX_COUNT;
               state_in = ST_ALIGN;
            end
         end
         ST_ALIGN: begin
            // Drop leading zeros, keeping at least one digit
            if (top_digit == '0 && count_ff != 4'd1) begin
               cell_ctrl.op = CELL_DIGIT;
               count_in     = count_ff - 4'd1;
            end else begin
               pos_in   = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // Load one digit beat whenever the output register is free
            if (slot_free) begin
               cell_ctrl.op = CELL_DIGIT;
               rsp_valid_in = 1'b1;
               rsp_char_in  = ASCII_ZERO + {2'b00, top_digit};
               rsp_pos_in   = pos_ff;
               rsp_count_in = count_ff;
               rsp_last_in  = (pos_ff == count_ff - 4'd1);
               pos_in       = pos_ff + 4'd1;
               if (pos_ff == count_ff - 4'd1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      bin_ff       <= bin_in;
      bit_cnt_ff   <= bit_cnt_in;
      count_ff     <= count_in;
      pos_ff       <= pos_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_count_ff, rsp_pos_ff, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;

   `ASSERT_PROP(a_req_starts_conv, clock, reset, req_beat |=> state_ff == ST_CONV, "accepted value did not start conversion")
   `ASSERT_NEVER(a_no_overflow, clock, reset, state_ff == ST_CONV && carry_w[NUM_DIGITS], "carry left the top digit cell")
   `ASSERT_PROP(a_count_range, clock, reset, state_ff == ST_EMIT |-> count_ff >= 4'd1 && count_ff <= MAX_COUNT, "digit count out of range")
   `ASSERT_PROP(a_top_is_bcd, clock, reset, state_ff == ST_EMIT |-> top_digit <= 4'd9, "emitted digit is not decimal")
   `ASSERT_PROP(a_lead_nonzero, clock, reset, state_ff == ST_EMIT && pos_ff == 4'd0 && count_ff != 4'd1 |-> top_digit != 4'd0, "leading zero reached emission")

endmodule
